>>> sv/class_file_header_pool_parser_macros.svh
// Assertion macros shared by the checker.
`ifndef CLASS_FILE_HEADER_POOL_PARSER_MACROS_SVH
`define CLASS_FILE_HEADER_POOL_PARSER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CFP_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define CFP_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

>>> sv/cfp_pkg.sv
package cfp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]  record_kind;
        logic [15:0] entry_number;
        logic [7:0]  entry_tag;
        logic [31:0] first_value;
        logic [15:0] second_value;
        logic [16:0] entry_bytes;
        logic        file_done;
    } out_beat_t;

    typedef enum logic [3:0] {
        PH_MAGIC, PH_MINOR, PH_MAJOR, PH_PCOUNT, PH_TAG, PH_IDXA, PH_IDXB,
        PH_TLEN, PH_TEXT, PH_ACCESS, PH_THIS, PH_SUPER, PH_ICOUNT, PH_IFACE,
        PH_DONE
    } phase_t;

    localparam logic [3:0] RK_MAGIC   = 4'd0;
    localparam logic [3:0] RK_MINOR   = 4'd1;
    localparam logic [3:0] RK_MAJOR   = 4'd2;
    localparam logic [3:0] RK_PCOUNT  = 4'd3;
    localparam logic [3:0] RK_ENTRY   = 4'd4;
    localparam logic [3:0] RK_TLEN    = 4'd5;
    localparam logic [3:0] RK_TEXT    = 4'd6;
    localparam logic [3:0] RK_ACCESS  = 4'd7;
    localparam logic [3:0] RK_THIS    = 4'd8;
    localparam logic [3:0] RK_SUPER   = 4'd9;
    localparam logic [3:0] RK_ICOUNT  = 4'd10;
    localparam logic [3:0] RK_IFACE   = 4'd11;
    localparam logic [3:0] RK_BADTAG  = 4'd12;

    localparam logic [7:0] TAG_UTF8       = 8'd1;
    localparam logic [7:0] TAG_CLASS      = 8'd7;
    localparam logic [7:0] TAG_FIELDREF   = 8'd9;
    localparam logic [7:0] TAG_METHODREF  = 8'd10;
    localparam logic [7:0] TAG_IFMETHOD   = 8'd11;
    localparam logic [7:0] TAG_NAMETYPE   = 8'd12;
    localparam logic [7:0] TAG_METHODTYPE = 8'd16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

endpackage

>>> sv/class_file_header_pool_parser.sv
// Class-file header and constant-pool parser.
// The in channel (in_valid/in_ready/in_data) takes one byte of a big-endian
// class-file image per beat; in_data.file_start marks the first byte of a file.
// The out channel (out_valid/out_ready/out_data) gives one record per completed
// field: header words, pool entries, Utf8 length and text bytes, access flags,
// this/super, interface count and indices, or a bad-tag record ending the file.
// One byte is accepted per cycle when the output is free. A two-entry byte
// queue feeds the parser; a record is written to the output register as its
// last byte leaves the queue, so a byte passes the queue and the output register.
// The per-byte phase update sets the rate of one byte per cycle while the output is free.
// When out_ready is low the output register holds its record, the parser
// stops, and the queue absorbs up to two more bytes before in_ready drops.
// Reset empties the queue and output and starts parsing at the magic number.
// After a file ends, bytes are dropped until a beat with file_start set.
module class_file_header_pool_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cfp_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cfp_pkg::out_beat_t out_data
);

    logic              q_valid, q_ready;
    cfp_pkg::in_beat_t q_data;

    cfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    cfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> sv/cfp_front.sv
module cfp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cfp_pkg::in_beat_t in_data,
    output logic              q_valid,
    input  logic              q_ready,
    output cfp_pkg::in_beat_t q_data
);

    cfp_pkg::in_beat_t        mem_reg [cfp_pkg::QUEUE_DEPTH];
    logic [cfp_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [cfp_pkg::QUEUE_AW:0]   count_reg, count_next;
    logic push, pop;

    assign in_ready = (count_reg != cfp_pkg::QUEUE_AW'(0) + (cfp_pkg::QUEUE_AW+1)'(cfp_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> sv/cfp_back.sv
module cfp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  cfp_pkg::in_beat_t  q_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cfp_pkg::out_beat_t out_data
);

    cfp_pkg::phase_t     phase_reg, phase_next, ph;
    logic [1:0]          bpos_reg, bpos_next;
    logic [31:0]         acc_reg, acc_next, v;
    logic [15:0]         ptotal_reg, ptotal_next;
    logic [15:0]         ppos_reg, ppos_next, ppos_inc;
    logic [7:0]          tag_reg, tag_next;
    logic [15:0]         held_reg, held_next;
    logic [15:0]         trem_reg, trem_next, trem_dec;
    logic [15:0]         itotal_reg, itotal_next;
    logic [15:0]         ipos_reg, ipos_next, ipos_inc;
    logic                ov_reg;
    cfp_pkg::out_beat_t  od_reg, rec;
    logic                emit, fire, complete;
    logic [2:0]          need;
    logic [31:0]         base_acc;
    logic [1:0]          base_pos;

    assign q_ready   = !ov_reg || out_ready;
    assign fire      = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb
    begin
        ph       = q_data.file_start ? cfp_pkg::PH_MAGIC : phase_reg;
        base_acc = q_data.file_start ? 32'd0 : acc_reg;
        base_pos = q_data.file_start ? 2'd0 : bpos_reg;
        v        = {base_acc[23:0], q_data.data_byte};
        if (ph == cfp_pkg::PH_MAGIC)
        begin
            need = 3'd4;
        end
        else if (ph == cfp_pkg::PH_TAG || ph == cfp_pkg::PH_TEXT)
        begin
            need = 3'd1;
        end
        else
        begin
            need = 3'd2;
        end
        complete = ({1'b0, base_pos} + 3'd1) >= need;
        ppos_inc = ppos_reg + 16'd1;
        ipos_inc = ipos_reg + 16'd1;
        trem_dec = trem_reg - 16'd1;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        bpos_next   = bpos_reg;
        acc_next    = acc_reg;
        ptotal_next = ptotal_reg;
        ppos_next   = ppos_reg;
        tag_next    = tag_reg;
        held_next   = held_reg;
        trem_next   = trem_reg;
        itotal_next = itotal_reg;
        ipos_next   = ipos_reg;
        emit        = 1'b0;
        rec         = '0;
        if (q_data.file_start)
        begin
            phase_next  = cfp_pkg::PH_MAGIC;
            bpos_next   = '0;
            acc_next    = '0;
            ptotal_next = '0;
            ppos_next   = '0;
            tag_next    = '0;
            held_next   = '0;
            trem_next   = '0;
            itotal_next = '0;
            ipos_next   = '0;
        end
        if (ph != cfp_pkg::PH_DONE)
        begin
            if (!complete)
            begin
                acc_next  = v;
                bpos_next = base_pos + 2'd1;
            end
            else
            begin
                acc_next  = '0;
                bpos_next = '0;
                rec.first_value = v;
                unique case (ph)
                    cfp_pkg::PH_MAGIC:
                    begin
                        emit = 1'b1; rec.record_kind = cfp_pkg::RK_MAGIC;
                        phase_next = cfp_pkg::PH_MINOR;
                    end
                    cfp_pkg::PH_MINOR:
                    begin
                        emit = 1'b1; rec.record_kind = cfp_pkg::RK_MINOR;
                        phase_next = cfp_pkg::PH_MAJOR;
                    end
                    cfp_pkg::PH_MAJOR:
                    begin
                        emit = 1'b1; rec.record_kind = cfp_pkg::RK_MAJOR;
                        phase_next = cfp_pkg::PH_PCOUNT;
                    end
                    cfp_pkg::PH_PCOUNT:
                    begin
                        emit = 1'b1; rec.record_kind = cfp_pkg::RK_PCOUNT;
                        ptotal_next = v[15:0];
                        ppos_next   = 16'd1;
                        phase_next  = (16'd1 < v[15:0]) ? cfp_pkg::PH_TAG
                                                        : cfp_pkg::PH_ACCESS;
                    end
                    cfp_pkg::PH_TAG:
                    begin
                        tag_next = v[7:0];
                        unique case (v[7:0]) inside
                            cfp_pkg::TAG_CLASS, cfp_pkg::TAG_METHODTYPE,
                            cfp_pkg::TAG_FIELDREF, cfp_pkg::TAG_METHODREF,
                            cfp_pkg::TAG_IFMETHOD, cfp_pkg::TAG_NAMETYPE:
                                phase_next = cfp_pkg::PH_IDXA;
                            cfp_pkg::TAG_UTF8:
                                phase_next = cfp_pkg::PH_TLEN;
                            default:
                            begin
                                emit = 1'b1;
                                rec.record_kind  = cfp_pkg::RK_BADTAG;
                                rec.entry_number = ppos_reg;
                                rec.entry_tag    = v[7:0];
                                rec.first_value  = '0;
                                rec.file_done    = 1'b1;
                                phase_next = cfp_pkg::PH_DONE;
                            end
                        endcase
                    end
                    cfp_pkg::PH_IDXA:
                    begin
                        if (tag_reg == cfp_pkg::TAG_CLASS ||
                            tag_reg == cfp_pkg::TAG_METHODTYPE)
                        begin
                            emit = 1'b1; rec.record_kind = cfp_pkg::RK_ENTRY;
                            rec.entry_number = ppos_reg;
                            rec.entry_tag    = tag_reg;
                            rec.entry_bytes  = 17'd3;
                            ppos_next  = ppos_inc;
                            phase_next = (ppos_inc < ptotal_reg) ? cfp_pkg::PH_TAG
                                                                 : cfp_pkg::PH_ACCESS;
                        end
                        else
                        begin
                            held_next  = v[15:0];
                            phase_next = cfp_pkg::PH_IDXB;
                        end
                    end
                    cfp_pkg::PH_IDXB:
                    begin
                        emit = 1'b1; rec.record_kind = cfp_pkg::RK_ENTRY;
                        rec.entry_number = ppos_reg;
                        rec.entry_tag    = tag_reg;
                        rec.first_value  = {16'd0, held_reg};
                        rec.second_value = v[15:0];
                        rec.entry_bytes  = 17'd5;
                        ppos_next  = ppos_inc;
                        phase_next = (ppos_inc < ptotal_reg) ? cfp_pkg::PH_TAG
                                                             : cfp_pkg::PH_ACCESS;
                    end
                    cfp_pkg::PH_TLEN:
                    begin
                        emit = 1'b1; rec.record_kind = cfp_pkg::RK_TLEN;
                        rec.entry_number = ppos_reg;
                        rec.entry_tag    = tag_reg;
                        rec.first_value  = {16'd0, v[15:0]};
                        rec.entry_bytes  = {1'b0, v[15:0]} + 17'd2;
                        held_next = v[15:0];
                        trem_next = v[15:0];
                        if (v[15:0] == 16'd0)
                        begin
                            ppos_next  = ppos_inc;
                            phase_next = (ppos_inc < ptotal_reg) ? cfp_pkg::PH_TAG
                                                                 : cfp_pkg::PH_ACCESS;
                        end
                        else
                        begin
                            phase_next = cfp_pkg::PH_TEXT;
                        end
                    end
                    cfp_pkg::PH_TEXT:
                    begin
                        emit = 1'b1; rec.record_kind = cfp_pkg::RK_TEXT;
                        rec.entry_number = ppos_reg;
                        rec.entry_tag    = tag_reg;
                        rec.entry_bytes  = {1'b0, held_reg} + 17'd2;
                        trem_next = trem_dec;
                        if (trem_dec == 16'd0)
                        begin
                            ppos_next  = ppos_inc;
                            phase_next = (ppos_inc < ptotal_reg) ? cfp_pkg::PH_TAG
                                                                 : cfp_pkg::PH_ACCESS;
                        end
                    end
                    cfp_pkg::PH_ACCESS:
                    begin
                        emit = 1'b1; rec.record_kind = cfp_pkg::RK_ACCESS;
                        phase_next = cfp_pkg::PH_THIS;
                    end
                    cfp_pkg::PH_THIS:
                    begin
                        emit = 1'b1; rec.record_kind = cfp_pkg::RK_THIS;
                        phase_next = cfp_pkg::PH_SUPER;
                    end
                    cfp_pkg::PH_SUPER:
                    begin
                        emit = 1'b1; rec.record_kind = cfp_pkg::RK_SUPER;
                        phase_next = cfp_pkg::PH_ICOUNT;
                    end
                    cfp_pkg::PH_ICOUNT:
                    begin
                        emit = 1'b1; rec.record_kind = cfp_pkg::RK_ICOUNT;
                        itotal_next    = v[15:0];
                        ipos_next      = '0;
                        rec.file_done  = (v[15:0] == 16'd0);
                        phase_next = (v[15:0] == 16'd0) ? cfp_pkg::PH_DONE
                                                        : cfp_pkg::PH_IFACE;
                    end
                    cfp_pkg::PH_IFACE:
                    begin
                        emit = 1'b1; rec.record_kind = cfp_pkg::RK_IFACE;
                        rec.entry_number = ipos_reg;
                        rec.file_done    = (ipos_inc >= itotal_reg);
                        ipos_next = ipos_inc;
                        if (ipos_inc >= itotal_reg)
                        begin
                            phase_next = cfp_pkg::PH_DONE;
                        end
                    end
                    default:
                    begin
                        phase_next = cfp_pkg::PH_DONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            od_reg <= rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= cfp_pkg::PH_MAGIC;
            bpos_reg   <= '0;
            acc_reg    <= '0;
            ptotal_reg <= '0;
            ppos_reg   <= '0;
            tag_reg    <= '0;
            held_reg   <= '0;
            trem_reg   <= '0;
            itotal_reg <= '0;
            ipos_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg  <= phase_next;
                bpos_reg   <= bpos_next;
                acc_reg    <= acc_next;
                ptotal_reg <= ptotal_next;
                ppos_reg   <= ppos_next;
                tag_reg    <= tag_next;
                held_reg   <= held_next;
                trem_reg   <= trem_next;
                itotal_reg <= itotal_next;
                ipos_reg   <= ipos_next;
            end
            if (fire)
            begin
                ov_reg <= emit;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

endmodule

>>> sv/cfp_checker.sv
`include "class_file_header_pool_parser_macros.svh"

module cfp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input cfp_pkg::in_beat_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input cfp_pkg::out_beat_t out_data
);

    `CFP_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready,
        in_valid && $stable(in_data), "input beat changed while waiting")
    `CFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_data), "output record changed while stalled")
    `CFP_ASSERT_IMP(a_kind_range, clk, rst_n, out_valid,
        out_data.record_kind <= cfp_pkg::RK_BADTAG, "record kind out of range")
    `CFP_ASSERT_IMP(a_bad_done, clk, rst_n,
        out_valid && out_data.record_kind == cfp_pkg::RK_BADTAG,
        out_data.file_done, "bad tag record without file end")
    `CFP_ASSERT_IMP(a_header_clean, clk, rst_n,
        out_valid && (out_data.record_kind == cfp_pkg::RK_MAGIC ||
        out_data.record_kind == cfp_pkg::RK_MINOR),
        out_data.entry_tag == 8'd0 && !out_data.file_done,
        "header record carries pool fields")

endmodule

bind class_file_header_pool_parser cfp_checker u_cfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> tb/class_file_header_pool_parser_tb.sv
module class_file_header_pool_parser_tb;

    localparam int WATCHDOG_LIMIT = 5000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    cfp_pkg::in_beat_t  in_data;
    logic               out_valid;
    logic               out_ready = 1'b1;
    cfp_pkg::out_beat_t out_data;

    int        error_count = 0;
    int        idle_cycles = 0;
    int        send_idle_pct;
    int        recv_stall_pct;
    cfp_pkg::out_beat_t expected_records[$];
    byte unsigned file_image[$];

    cfp_pkg::phase_t pr_phase;
    logic [1:0]  pr_bytepos;
    logic [31:0] pr_acc;
    logic [15:0] pr_pool_total;
    logic [15:0] pr_pool_pos;
    logic [7:0]  pr_tag;
    logic [15:0] pr_held;
    logic [15:0] pr_text_left;
    logic [15:0] pr_iface_total;
    logic [15:0] pr_iface_pos;

    class_file_header_pool_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic cfp_pkg::out_beat_t make_record(logic [3:0] kind,
                                                       logic [15:0] num,
                                                       logic [7:0] tag,
                                                       logic [31:0] v1,
                                                       logic [15:0] v2,
                                                       logic [16:0] nb,
                                                       logic done);
        cfp_pkg::out_beat_t r;
        r.record_kind  = kind;
        r.entry_number = num;
        r.entry_tag    = tag;
        r.first_value  = v1;
        r.second_value = v2;
        r.entry_bytes  = nb;
        r.file_done    = done;
        return r;
    endfunction

    task automatic expect_record(cfp_pkg::out_beat_t r);
        expected_records.insert(expected_records.size(), r);
    endtask

    task automatic append_byte(logic [7:0] b);
        file_image.insert(file_image.size(), b);
    endtask

    task automatic parser_clear();
        pr_phase       = cfp_pkg::PH_MAGIC;
        pr_bytepos     = '0;
        pr_acc         = '0;
        pr_pool_total  = '0;
        pr_pool_pos    = '0;
        pr_tag         = '0;
        pr_held        = '0;
        pr_text_left   = '0;
        pr_iface_total = '0;
        pr_iface_pos   = '0;
    endtask

    task automatic advance_entry();
        pr_pool_pos = pr_pool_pos + 16'd1;
        pr_phase    = (pr_pool_pos < pr_pool_total) ? cfp_pkg::PH_TAG
                                                    : cfp_pkg::PH_ACCESS;
    endtask

    task automatic predict_record(cfp_pkg::in_beat_t beat);
        logic [2:0]  pos;
        logic [2:0]  need;
        logic [31:0] v;
        logic [15:0] here;
        logic        last;
        if (beat.file_start)
            parser_clear();
        if (pr_phase == cfp_pkg::PH_DONE)
            return;
        pr_acc = {pr_acc[23:0], beat.data_byte};
        pos = pr_bytepos + 3'd1;
        need = (pr_phase == cfp_pkg::PH_MAGIC) ? 3'd4 :
               ((pr_phase == cfp_pkg::PH_TAG || pr_phase == cfp_pkg::PH_TEXT) ? 3'd1
                                                                           : 3'd2);
        if (pos < need)
        begin
            pr_bytepos = pos[1:0];
            return;
        end
        v = pr_acc;
        pr_acc = '0;
        pr_bytepos = '0;
        case (pr_phase)
            cfp_pkg::PH_MAGIC:
            begin
                expect_record(make_record(cfp_pkg::RK_MAGIC, 0, 0, v, 0, 0, 0));
                pr_phase = cfp_pkg::PH_MINOR;
            end
            cfp_pkg::PH_MINOR:
            begin
                expect_record(make_record(cfp_pkg::RK_MINOR, 0, 0, v, 0, 0, 0));
                pr_phase = cfp_pkg::PH_MAJOR;
            end
            cfp_pkg::PH_MAJOR:
            begin
                expect_record(make_record(cfp_pkg::RK_MAJOR, 0, 0, v, 0, 0, 0));
                pr_phase = cfp_pkg::PH_PCOUNT;
            end
            cfp_pkg::PH_PCOUNT:
            begin
                expect_record(make_record(cfp_pkg::RK_PCOUNT, 0, 0, v, 0, 0, 0));
                pr_pool_total = v[15:0];
                pr_pool_pos = 16'd1;
                pr_phase = (pr_pool_pos < pr_pool_total) ? cfp_pkg::PH_TAG
                                                         : cfp_pkg::PH_ACCESS;
            end
            cfp_pkg::PH_TAG:
            begin
                pr_tag = v[7:0];
                if (pr_tag inside {cfp_pkg::TAG_CLASS, cfp_pkg::TAG_METHODTYPE,
                                   cfp_pkg::TAG_FIELDREF, cfp_pkg::TAG_METHODREF,
                                   cfp_pkg::TAG_IFMETHOD, cfp_pkg::TAG_NAMETYPE})
                    pr_phase = cfp_pkg::PH_IDXA;
                else if (pr_tag == cfp_pkg::TAG_UTF8)
                    pr_phase = cfp_pkg::PH_TLEN;
                else
                begin
                    expect_record(make_record(cfp_pkg::RK_BADTAG, pr_pool_pos,
                                              pr_tag, 0, 0, 0, 1));
                    pr_phase = cfp_pkg::PH_DONE;
                end
            end
            cfp_pkg::PH_IDXA:
            begin
                if (pr_tag == cfp_pkg::TAG_CLASS || pr_tag == cfp_pkg::TAG_METHODTYPE)
                begin
                    expect_record(make_record(cfp_pkg::RK_ENTRY, pr_pool_pos,
                                              pr_tag, v, 0, 17'd3, 0));
                    advance_entry();
                end
                else
                begin
                    pr_held = v[15:0];
                    pr_phase = cfp_pkg::PH_IDXB;
                end
            end
            cfp_pkg::PH_IDXB:
            begin
                expect_record(make_record(cfp_pkg::RK_ENTRY, pr_pool_pos, pr_tag,
                                          {16'd0, pr_held}, v[15:0], 17'd5, 0));
                advance_entry();
            end
            cfp_pkg::PH_TLEN:
            begin
                pr_held = v[15:0];
                pr_text_left = pr_held;
                expect_record(make_record(cfp_pkg::RK_TLEN, pr_pool_pos, pr_tag,
                                          {16'd0, pr_held}, 0,
                                          {1'b0, pr_held} + 17'd2, 0));
                if (pr_text_left == 0)
                    advance_entry();
                else
                    pr_phase = cfp_pkg::PH_TEXT;
            end
            cfp_pkg::PH_TEXT:
            begin
                pr_text_left = pr_text_left - 16'd1;
                expect_record(make_record(cfp_pkg::RK_TEXT, pr_pool_pos, pr_tag,
                                          v, 0, {1'b0, pr_held} + 17'd2, 0));
                if (pr_text_left == 0)
                    advance_entry();
            end
            cfp_pkg::PH_ACCESS:
            begin
                expect_record(make_record(cfp_pkg::RK_ACCESS, 0, 0, v, 0, 0, 0));
                pr_phase = cfp_pkg::PH_THIS;
            end
            cfp_pkg::PH_THIS:
            begin
                expect_record(make_record(cfp_pkg::RK_THIS, 0, 0, v, 0, 0, 0));
                pr_phase = cfp_pkg::PH_SUPER;
            end
            cfp_pkg::PH_SUPER:
            begin
                expect_record(make_record(cfp_pkg::RK_SUPER, 0, 0, v, 0, 0, 0));
                pr_phase = cfp_pkg::PH_ICOUNT;
            end
            cfp_pkg::PH_ICOUNT:
            begin
                pr_iface_total = v[15:0];
                pr_iface_pos = '0;
                expect_record(make_record(cfp_pkg::RK_ICOUNT, 0, 0, v, 0, 0,
                                          pr_iface_total == 0));
                pr_phase = (pr_iface_total == 0) ? cfp_pkg::PH_DONE
                                                 : cfp_pkg::PH_IFACE;
            end
            cfp_pkg::PH_IFACE:
            begin
                here = pr_iface_pos;
                pr_iface_pos = pr_iface_pos + 16'd1;
                last = (pr_iface_pos >= pr_iface_total);
                expect_record(make_record(cfp_pkg::RK_IFACE, here, 0, v, 0, 0, last));
                if (last)
                    pr_phase = cfp_pkg::PH_DONE;
            end
            default:
                pr_phase = cfp_pkg::PH_DONE;
        endcase
    endtask

    // Valid stays high from one beat to the next unless the sender idles.
    task automatic send_byte(logic [7:0] b, logic start);
        cfp_pkg::in_beat_t beat;
        beat.data_byte  = b;
        beat.file_start = start;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_record(beat);
    endtask

    task automatic send_image(bit mark_start);
        foreach (file_image[i])
            send_byte(file_image[i], mark_start && i == 0);
    endtask

    task automatic push16(int v);
        append_byte(v[15:8]);
        append_byte(v[7:0]);
    endtask

    task automatic build_header(int pool_count);
        file_image.delete();
        push16(16'hCAFE);
        push16(16'hBABE);
        push16($urandom_range(65535));
        push16($urandom_range(65535));
        push16(pool_count);
    endtask

    task automatic build_entry(logic [7:0] tag, int text_len);
        append_byte(tag);
        if (tag == cfp_pkg::TAG_UTF8)
        begin
            push16(text_len);
            for (int k = 0; k < text_len; k++)
                append_byte($urandom_range(255));
        end
        else if (tag == cfp_pkg::TAG_CLASS || tag == cfp_pkg::TAG_METHODTYPE)
            push16($urandom_range(65535));
        else
        begin
            push16($urandom_range(65535));
            push16($urandom_range(65535));
        end
    endtask

    task automatic build_tail(int iface_count);
        push16($urandom_range(65535));
        push16($urandom_range(65535));
        push16($urandom_range(65535));
        push16(iface_count);
        for (int k = 0; k < iface_count; k++)
            push16($urandom_range(65535));
    endtask

    function automatic logic [7:0] pick_tag();
        logic [7:0] tags[7] = '{cfp_pkg::TAG_UTF8, cfp_pkg::TAG_CLASS,
                                cfp_pkg::TAG_FIELDREF, cfp_pkg::TAG_METHODREF,
                                cfp_pkg::TAG_IFMETHOD, cfp_pkg::TAG_NAMETYPE,
                                cfp_pkg::TAG_METHODTYPE};
        return tags[$urandom_range(6)];
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_directed_extremes();
        build_header(4);
        file_image[0] = 8'hFF; file_image[1] = 8'hFF;
        file_image[2] = 8'hFF; file_image[3] = 8'hFF;
        build_entry(cfp_pkg::TAG_UTF8, 0);
        build_entry(cfp_pkg::TAG_FIELDREF, 0);
        build_entry(cfp_pkg::TAG_UTF8, 2);
        build_tail(1);
        send_image(1'b0);
        wait_drained();
    endtask

    task automatic test_every_tag_and_bad_tag();
        build_header(8);
        build_entry(cfp_pkg::TAG_CLASS, 0);
        build_entry(cfp_pkg::TAG_METHODREF, 0);
        build_entry(cfp_pkg::TAG_IFMETHOD, 0);
        build_entry(cfp_pkg::TAG_NAMETYPE, 0);
        build_entry(cfp_pkg::TAG_METHODTYPE, 0);
        append_byte(8'hFF);
        append_byte(8'h00);
        send_image(1'b1);
        build_header(2);
        append_byte(8'h00);
        send_image(1'b1);
    endtask

    task automatic test_empty_pool_no_ifaces();
        build_header(0);
        build_tail(0);
        send_image(1'b1);
        build_header(1);
        build_tail(2);
        append_byte(8'h12);
        send_image(1'b1);
        wait_drained();
    endtask

    task automatic test_random_files(int byte_budget);
        int sent;
        int pool_count;
        sent = 0;
        while (sent < byte_budget)
        begin
            pool_count = $urandom_range(5);
            build_header(pool_count);
            for (int e = 1; e < pool_count; e++)
                build_entry(pick_tag(), $urandom_range(4));
            if ($urandom_range(9) == 0)
                append_byte($urandom_range(255));
            build_tail($urandom_range(3));
            if ($urandom_range(7) == 0)
                file_image = file_image[0:$urandom_range(file_image.size() - 1)];
            if ($urandom_range(9) == 0)
                file_image[$urandom_range(file_image.size() - 1)] = $urandom_range(255);
            send_image(1'b1);
            sent += file_image.size();
        end
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        cfp_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_records.size() == 0)
            begin
                $error("record with none expected: %p", out_data);
                error_count++;
            end
            else
            begin
                want = expected_records.pop_front();
                if (out_data.record_kind !== want.record_kind)
                begin
                    $error("record_kind expected %0d actual %0d",
                           want.record_kind, out_data.record_kind);
                    error_count++;
                end
                if (out_data.entry_number !== want.entry_number)
                begin
                    $error("entry_number expected %0d actual %0d",
                           want.entry_number, out_data.entry_number);
                    error_count++;
                end
                if (out_data.entry_tag !== want.entry_tag)
                begin
                    $error("entry_tag expected %0d actual %0d",
                           want.entry_tag, out_data.entry_tag);
                    error_count++;
                end
                if (out_data.first_value !== want.first_value)
                begin
                    $error("first_value expected %0h actual %0h",
                           want.first_value, out_data.first_value);
                    error_count++;
                end
                if (out_data.second_value !== want.second_value)
                begin
                    $error("second_value expected %0h actual %0h",
                           want.second_value, out_data.second_value);
                    error_count++;
                end
                if (out_data.entry_bytes !== want.entry_bytes)
                begin
                    $error("entry_bytes expected %0d actual %0d",
                           want.entry_bytes, out_data.entry_bytes);
                    error_count++;
                end
                if (out_data.file_done !== want.file_done)
                begin
                    $error("file_done expected %0d actual %0d",
                           want.file_done, out_data.file_done);
                    error_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        parser_clear();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_every_tag_and_bad_tag();
        test_empty_pool_no_ifaces();
        test_random_files(100);
        send_idle_pct = 56;
        test_random_files(100);
        send_idle_pct  = 0;
        recv_stall_pct = 56;
        test_random_files(100);
        send_idle_pct = 18;
        recv_stall_pct = 18;
        test_random_files(100);
        wait_drained();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
